### hdl/tdsm_pkg.sv
// ----------------------------------------------------------------------------
// tdsm_pkg: shared types and codes of the transition table state machine
// Action and status codes, register indexes, size limits and the structs
// that travel between the top level and the row of table cells.
// ----------------------------------------------------------------------------
package tdsm_pkg;

    // size limits; register values above them saturate
    localparam int MAX_STATES        = 16;
    localparam int MAX_SYMBOLS       = 16;
    localparam int DEF_TABLE_DEPTH   = 32;

    localparam int STATE_W  = 4;
    localparam int SYMBOL_W = 4;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 3;
    localparam int ACTION_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // actions
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPLY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SET   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_MOVED       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INPUT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SET_CHANGED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SET_SAME    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_STATE   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_LOADED      = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STATES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd2;

    // search probe handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic                found;
        logic [STATE_W-1:0]  state;
        logic [SYMBOL_W-1:0] symbol;
        logic [STATE_W-1:0]  dst_state;
        logic [INDEX_W-1:0]  idx;
    } t_probe;

    // table entry write broadcast to all cells
    typedef struct packed {
        logic                en;
        logic [INDEX_W-1:0]  idx;
        logic [STATE_W-1:0]  src_state;
        logic [SYMBOL_W-1:0] symbol;
        logic [STATE_W-1:0]  dst_state;
    } t_load;

endpackage

### hdl/tdsm_cell.sv
// ----------------------------------------------------------------------------
// tdsm_cell: one transition table entry with its search stage
// Holds one entry and passes the search probe on to the next cell, marking
// the first hit when the entry is in use and matches the probe's key.
// ----------------------------------------------------------------------------
module tdsm_cell
    import tdsm_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_load                 i_load,
    input  logic [CFG_DATA_W-1:0] i_entries,
    input  t_probe                i_probe,
    output t_probe                o_probe
);

    logic [STATE_W-1:0]  r_from;
    logic [SYMBOL_W-1:0] r_sym;
    logic [STATE_W-1:0]  r_to;
    t_probe              r_probe;
    t_probe              n_probe;
    logic                w_active;
    logic                w_hit;

    assign w_active = CELL_IDX < int'(i_entries);
    assign w_hit    = i_probe.valid && !i_probe.found && w_active
                      && (r_from == i_probe.state) && (r_sym == i_probe.symbol);

    always_comb begin
        n_probe = i_probe;
        if (w_hit) begin
            n_probe.found     = 1'b1;
            n_probe.dst_state = r_to;
            n_probe.idx       = INDEX_W'(CELL_IDX);
        end
    end

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_load.en && (int'(i_load.idx) == CELL_IDX)) begin
            r_from <= i_load.src_state;
            r_sym  <= i_load.symbol;
            r_to   <= i_load.dst_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= n_probe.valid;
        end
        r_probe.found     <= n_probe.found;
        r_probe.state     <= n_probe.state;
        r_probe.symbol    <= n_probe.symbol;
        r_probe.dst_state <= n_probe.dst_state;
        r_probe.idx       <= n_probe.idx;
    end

    assign o_probe = r_probe;

endmodule

### hdl/table_driven_state_machine.sv
// ----------------------------------------------------------------------------
// table_driven_state_machine: programmable transition table state machine
// Keeps a current state and a table of transitions searched by a row of cells.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. Load, set and
// rejected items give their result in the next cycle (one item per cycle). An
// apply item with a valid symbol and a known state sends a search probe down
// the row of TABLE_DEPTH cells, one cell per cycle; its result is registered
// when the probe leaves the last cell, and busy stays high meanwhile. Each
// result is shown for exactly one cycle with o_valid high and cannot be held
// off, so the receiver must take it then. Table entries are undefined until
// loaded: never let entries_in_use cover an entry that was not loaded.
// Configuration writes are taken at any cycle but are meant for idle time.
// ----------------------------------------------------------------------------
module table_driven_state_machine
    import tdsm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // command
    input  logic                  start,
    output logic                  busy,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [INDEX_W-1:0]    i_entry_index,
    input  logic [STATE_W-1:0]    i_entry_from,
    input  logic [SYMBOL_W-1:0]   i_input_symbol,
    input  logic [STATE_W-1:0]    i_target_state,
    // result
    output logic                  o_valid,
    output logic [STATUS_W-1:0]   o_status,
    output logic [STATE_W-1:0]    o_prior_state,
    output logic [STATE_W-1:0]    o_new_state,
    output logic                  o_state_known,
    output logic [INDEX_W-1:0]    o_matched_entry
);

    // configuration registers
    logic [4:0]            r_states;
    logic [4:0]            r_symbols;
    logic [CFG_DATA_W-1:0] r_entries;

    // machine state
    logic [STATE_W-1:0]    r_cur;
    logic                  r_known;
    logic                  r_scan;

    // result register
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status;
    logic [STATE_W-1:0]    r_prior;
    logic [STATE_W-1:0]    r_new;
    logic                  r_out_known;
    logic [INDEX_W-1:0]    r_matched;

    logic                  w_accept;
    logic [8:0]            w_nst;
    logic [8:0]            w_nsym;
    logic                  w_sym_ok;
    logic                  w_state_ok;
    t_load                 w_load;
    t_probe                w_chain [0:TABLE_DEPTH];
    t_probe                w_tail;

    assign busy     = r_scan;
    assign w_accept = start && !r_scan;

    // saturate the range registers to the size limits
    assign w_nst  = ({4'd0, r_states} > 9'(MAX_STATES)) ? 9'(MAX_STATES)
                                                          : {4'd0, r_states};
    assign w_nsym = ({4'd0, r_symbols} > 9'(MAX_SYMBOLS)) ? 9'(MAX_SYMBOLS)
                                                            : {4'd0, r_symbols};
    assign w_sym_ok   = {5'd0, i_input_symbol} < w_nsym;
    assign w_state_ok = {5'd0, i_target_state} < w_nst;

    // load broadcast; a cell takes it only when the index is its own, so an
    // index beyond the row writes nothing
    always_comb begin
        w_load.en        = w_accept && (i_action == ACT_LOAD);
        w_load.idx       = i_entry_index;
        w_load.src_state = i_entry_from;
        w_load.symbol    = i_input_symbol;
        w_load.dst_state = i_target_state;
    end

    // launch a probe only when a search can hit: valid symbol and known state
    always_comb begin
        w_chain[0].valid     = w_accept && (i_action == ACT_APPLY) && w_sym_ok && r_known;
        w_chain[0].found     = 1'b0;
        w_chain[0].state     = r_cur;
        w_chain[0].symbol    = i_input_symbol;
        w_chain[0].dst_state = '0;
        w_chain[0].idx       = '0;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        tdsm_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (w_load),
            .i_entries (r_entries),
            .i_probe   (w_chain[g]),
            .o_probe   (w_chain[g+1])
        );
    end

    assign w_tail = w_chain[TABLE_DEPTH];

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_states  <= 5'd16;
            r_symbols <= 5'd16;
            r_entries <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STATES:  r_states  <= i_cfg_data[4:0];
                CFG_SYMBOLS: r_symbols <= i_cfg_data[4:0];
                CFG_ENTRIES: r_entries <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // item handling and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_known     <= 1'b0;
            r_scan      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (r_scan) begin
                // wait for the probe to leave the last cell
                if (w_tail.valid) begin
                    r_scan      <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_prior     <= r_cur;
                    r_out_known <= r_known;
                    if (w_tail.found) begin
                        r_cur     <= w_tail.dst_state;
                        r_new     <= w_tail.dst_state;
                        r_status  <= ST_MOVED;
                        r_matched <= w_tail.idx;
                    end else begin
                        r_new     <= r_cur;
                        r_status  <= ST_NONE;
                        r_matched <= '0;
                    end
                end
            end else if (w_accept) begin
                r_prior     <= r_cur;
                r_new       <= r_cur;
                r_out_known <= r_known;
                r_matched   <= '0;
                case (i_action)
                    ACT_LOAD: begin
                        r_out_valid <= 1'b1;
                        r_status    <= ST_LOADED;
                    end
                    ACT_APPLY: begin
                        if (!w_sym_ok) begin
                            r_out_valid <= 1'b1;
                            r_status    <= ST_BAD_INPUT;
                        end else if (!r_known) begin
                            // no state yet: nothing can match
                            r_out_valid <= 1'b1;
                            r_status    <= ST_NONE;
                        end else begin
                            r_scan <= 1'b1;
                        end
                    end
                    ACT_SET: begin
                        r_out_valid <= 1'b1;
                        if (!w_state_ok) begin
                            r_status <= ST_BAD_STATE;
                        end else if (!r_known || (i_target_state != r_cur)) begin
                            r_cur       <= i_target_state;
                            r_known     <= 1'b1;
                            r_new       <= i_target_state;
                            r_out_known <= 1'b1;
                            r_status    <= ST_SET_CHANGED;
                        end else begin
                            r_status <= ST_SET_SAME;
                        end
                    end
                    default: begin
                        // unused action: report a bad input, change nothing
                        r_out_valid <= 1'b1;
                        r_status    <= ST_BAD_INPUT;
                    end
                endcase
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_prior_state   = r_prior;
    assign o_new_state     = r_new;
    assign o_state_known   = r_out_known;
    assign o_matched_entry = r_matched;

endmodule

### hdl/tdsm_checker.sv
// ----------------------------------------------------------------------------
// tdsm_checker: port level checks of the transition table state machine
// Watches the command and result ports and flags results that break the
// block's rules; bound to the top level below.
// ----------------------------------------------------------------------------
module tdsm_checker
    import tdsm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [STATUS_W-1:0]   o_status,
    input logic [STATE_W-1:0]    o_prior_state,
    input logic [STATE_W-1:0]    o_new_state,
    input logic                  o_state_known,
    input logic [INDEX_W-1:0]    o_matched_entry
);

    // an accepted item either answers at once or starts a search
    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_valid || busy)
        else $error("accepted item neither answered nor started a search");

    // a search ends with its result
    a_search_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_valid)
        else $error("search ended without a result");

    // a move or a successful set needs a known state
    a_known_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_MOVED || o_status == ST_SET_CHANGED
                    || o_status == ST_SET_SAME) |-> o_state_known)
        else $error("state reported unknown after move or set");

    // results that change nothing keep the state
    a_state_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_SET_SAME || o_status == ST_NONE
                    || o_status == ST_BAD_INPUT || o_status == ST_BAD_STATE
                    || o_status == ST_LOADED) |-> o_prior_state == o_new_state)
        else $error("state changed by an item that must keep it");

    // only a move reports a table entry
    a_matched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_MOVED |-> o_matched_entry == '0)
        else $error("matched entry reported without a move");

endmodule

bind table_driven_state_machine tdsm_checker u_tdsm_checker (.*);
